// ===== design/sse_last_event_data_extractor_defines.svh =====
// assertion macros for the sse last-event data extractor checker
`ifndef SSE_LAST_EVENT_DATA_EXTRACTOR_DEFINES_SVH
`define SSE_LAST_EVENT_DATA_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SSE_LED_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sse_led check failed");

// next-cycle implication, disabled while reset is asserted
`define SSE_LED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sse_led check failed");

`endif

// ===== design/sse_led_pkg.sv =====
// types and constants shared by the sse last-event data extractor
`timescale 1ns / 1ps
package sse_led_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam int unsigned TAG_LEN = 5;

  localparam int unsigned LEN_W = 13;
  localparam int unsigned IDX_W = 12;

  localparam int unsigned CMD_FIFO_DEPTH = 4;
  localparam int unsigned OUT_FIFO_DEPTH = 4;

  typedef struct packed {
    op_e              op;
    logic [7:0]       body_byte;
    logic [IDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic             event_found;
    logic [LEN_W-1:0] event_length;
    logic             event_truncated;
    logic [7:0]       read_byte;
    logic             read_valid;
  } out_t;

  // work handed from the parser to the bank store
  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic             truncated;
    logic             rd_en;
    logic             bank;
    logic             wr0_en;
    logic [7:0]       wr0_data;
    logic             wr1_en;
    logic [7:0]       wr1_data;
  } cmd_t;

  // characters of the "data:" field name
  function automatic logic [7:0] tag_byte(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h64;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h61;
      3'd4:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/sse_last_event_data_extractor.sv =====
// sse_last_event_data_extractor: one item per clock while full is low, parser then queue then bank store
// an item's result passes through the command queue, the registered store stage and the output queue
// throughput: 1 item per cycle while full is low; two bytes per cycle fit since each bank has even/odd halves
// reset: async active low, clears parse state, flags, lengths and both queues
// the bank memories are not cleared; only bytes below the stored length are read
`timescale 1ns / 1ps
module sse_last_event_data_extractor #(
  parameter int unsigned BANK_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sse_led_pkg::in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output sse_led_pkg::out_t out_o
);
  import sse_led_pkg::*;

  localparam int unsigned AW    = $clog2(BANK_DEPTH);
  localparam int unsigned CMD_W = $bits(cmd_t) + AW;
  localparam int unsigned OUT_W = $bits(out_t);
  localparam int unsigned OCW   = $clog2(OUT_FIFO_DEPTH+1);

  logic             accept;
  cmd_t             front_cmd, back_cmd;
  logic [AW-1:0]    front_addr, back_addr;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;
  logic             cmd_empty, cmd_pop;
  logic             out_push;
  out_t             store_out;
  logic [OUT_W-1:0] out_rdata;
  logic [OCW-1:0]   out_count;

  assign accept = push && !full;

  sse_led_front #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .cmd_o    (front_cmd),
    .addr_o   (front_addr)
  );

  assign cmd_wdata = {front_addr, front_cmd};

  sse_led_fifo #(
    .W     (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_wdata),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rdata),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o ()
  );

  assign back_addr = cmd_rdata[CMD_W-1 -: AW];
  assign back_cmd  = cmd_t'(cmd_rdata[$bits(cmd_t)-1:0]);

  sse_led_store #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (back_cmd),
    .addr_i      (back_addr),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_o       (store_out)
  );

  sse_led_fifo #(
    .W     (OUT_W),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (store_out),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .full_o  (),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_o = out_t'(out_rdata);

endmodule

// ===== design/sse_led_fifo.sv =====
// small register queue with full, empty and fill count
`timescale 1ns / 1ps
module sse_led_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [W-1:0]                 data_i,
  input  logic                         pop_i,
  output logic [W-1:0]                 data_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH+1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/sse_led_front.sv =====
// line parser: classifies each item and tracks event lengths and flags
`timescale 1ns / 1ps
module sse_led_front #(
  parameter int unsigned BANK_DEPTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  sse_led_pkg::in_t              in_i,
  output sse_led_pkg::cmd_t             cmd_o,
  output logic [$clog2(BANK_DEPTH)-1:0] addr_o
);
  import sse_led_pkg::*;

  localparam int unsigned AW = $clog2(BANK_DEPTH);
  localparam int unsigned LW = $clog2(BANK_DEPTH+1);
  localparam int unsigned CW = (LW > IDX_W) ? LW : IDX_W + 1;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_ONLY_CR,
    PH_SKIP,
    PH_VFIRST,
    PH_VALUE
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [2:0]    pcnt_q, pcnt_d;
  logic          crp_q, crp_d;
  logic          sel_q, sel_d;
  logic [LW-1:0] blen_q, blen_d;
  logic [LW-1:0] slen_q, slen_d;
  logic          cur_q, cur_d;
  logic          curtr_q, curtr_d;
  logic          last_q, last_d;
  logic          lasttr_q, lasttr_d;

  logic          put0, put1, wr0, wr1;
  logic [7:0]    data0, data1;
  logic          do_close, do_restart, set_cur, rd_hit;
  logic [7:0]    b;

  assign b = in_i.body_byte;

  always_comb begin
    phase_d    = phase_q;
    pcnt_d     = pcnt_q;
    crp_d      = crp_q;
    sel_d      = sel_q;
    blen_d     = blen_q;
    slen_d     = slen_q;
    cur_d      = cur_q;
    curtr_d    = curtr_q;
    last_d     = last_q;
    lasttr_d   = lasttr_q;
    put0       = 1'b0;
    put1       = 1'b0;
    data0      = '0;
    data1      = '0;
    do_close   = 1'b0;
    do_restart = 1'b0;
    set_cur    = 1'b0;
    rd_hit     = 1'b0;

    case (in_i.op)
      OP_BYTE: begin
        case (phase_q)
          PH_PREFIX: begin
            if (b == CH_LF) begin
              do_close   = (pcnt_q == '0);
              do_restart = 1'b1;
            end else if (pcnt_q == '0 && b == CH_CR) begin
              phase_d = PH_ONLY_CR;
            end else if (pcnt_q < 3'(TAG_LEN) && b == tag_byte(pcnt_q)) begin
              pcnt_d = pcnt_q + 3'd1;
              if (pcnt_q == 3'(TAG_LEN-1)) begin
                // further data lines of one event are joined by lf
                put0    = cur_q;
                data0   = CH_LF;
                set_cur = 1'b1;
                phase_d = PH_VFIRST;
              end
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_ONLY_CR: begin
            if (b == CH_LF) begin
              do_close   = 1'b1;
              do_restart = 1'b1;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            do_restart = (b == CH_LF);
          end
          PH_VFIRST: begin
            if (b == CH_LF) begin
              do_restart = 1'b1;
            end else if (b == CH_CR) begin
              crp_d   = 1'b1;
              phase_d = PH_VALUE;
            end else begin
              put0    = (b != CH_SP);
              data0   = b;
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            // a cr is held back until we know it does not end the line
            if (b == CH_LF) begin
              do_restart = 1'b1;
            end else if (b == CH_CR) begin
              put0  = crp_q;
              data0 = CH_CR;
              crp_d = 1'b1;
            end else if (crp_q) begin
              put0  = 1'b1;
              data0 = CH_CR;
              put1  = 1'b1;
              data1 = b;
              crp_d = 1'b0;
            end else begin
              put0  = 1'b1;
              data0 = b;
            end
          end
          default: begin
            do_restart = 1'b1;
          end
        endcase
      end
      OP_END: begin
        do_close   = 1'b1;
        do_restart = 1'b1;
      end
      OP_READ: begin
        rd_hit = last_q && (CW'(in_i.read_index) < CW'(slen_q));
      end
      default: begin
      end
    endcase

    wr0 = put0 && (blen_q < LW'(BANK_DEPTH));
    wr1 = put1 && (blen_q < LW'(BANK_DEPTH-1));
    if (put0 || put1) begin
      blen_d = blen_q + LW'(wr0) + LW'(wr1);
    end
    if ((put0 && !wr0) || (put1 && !wr1)) begin
      curtr_d = 1'b1;
    end
    if (set_cur) begin
      cur_d = 1'b1;
    end

    if (do_close) begin
      if (cur_q) begin
        sel_d    = ~sel_q;
        slen_d   = blen_q;
        last_d   = 1'b1;
        lasttr_d = curtr_q;
      end
      blen_d  = '0;
      cur_d   = 1'b0;
      curtr_d = 1'b0;
    end
    if (do_restart) begin
      phase_d = PH_PREFIX;
      pcnt_d  = '0;
      crp_d   = 1'b0;
    end

    if (in_i.op == OP_CLEAR) begin
      phase_d  = PH_PREFIX;
      pcnt_d   = '0;
      crp_d    = 1'b0;
      sel_d    = 1'b0;
      blen_d   = '0;
      slen_d   = '0;
      cur_d    = 1'b0;
      curtr_d  = 1'b0;
      last_d   = 1'b0;
      lasttr_d = 1'b0;
    end
  end

  always_comb begin
    cmd_o.found     = last_d;
    cmd_o.length    = LEN_W'(slen_d);
    cmd_o.truncated = lasttr_d;
    cmd_o.rd_en     = rd_hit;
    cmd_o.bank      = (in_i.op == OP_READ) ? sel_q : ~sel_q;
    cmd_o.wr0_en    = wr0;
    cmd_o.wr0_data  = data0;
    cmd_o.wr1_en    = wr1;
    cmd_o.wr1_data  = data1;
    addr_o          = (in_i.op == OP_READ) ? AW'(in_i.read_index) : blen_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PREFIX;
      pcnt_q   <= '0;
      crp_q    <= 1'b0;
      sel_q    <= 1'b0;
      blen_q   <= '0;
      slen_q   <= '0;
      cur_q    <= 1'b0;
      curtr_q  <= 1'b0;
      last_q   <= 1'b0;
      lasttr_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      pcnt_q   <= pcnt_d;
      crp_q    <= crp_d;
      sel_q    <= sel_d;
      blen_q   <= blen_d;
      slen_q   <= slen_d;
      cur_q    <= cur_d;
      curtr_q  <= curtr_d;
      last_q   <= last_d;
      lasttr_q <= lasttr_d;
    end
  end

endmodule

// ===== design/sse_led_store.sv =====
// event banks split into even and odd byte memories, plus the result stage
`timescale 1ns / 1ps
module sse_led_store #(
  parameter int unsigned BANK_DEPTH = 4096
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cmd_valid_i,
  input  sse_led_pkg::cmd_t                              cmd_i,
  input  logic [$clog2(BANK_DEPTH)-1:0]                  addr_i,
  output logic                                           cmd_pop_o,
  input  logic [$clog2(sse_led_pkg::OUT_FIFO_DEPTH+1)-1:0] out_count_i,
  output logic                                           out_push_o,
  output sse_led_pkg::out_t                              out_o
);
  import sse_led_pkg::*;

  localparam int unsigned AW        = $clog2(BANK_DEPTH);
  localparam int unsigned HW        = AW - 1;
  localparam int unsigned HALF      = (BANK_DEPTH + 1) / 2;
  localparam int unsigned MEM_DEPTH = 2 * HALF;
  localparam int unsigned IW        = $clog2(MEM_DEPTH);
  localparam int unsigned OCW       = $clog2(OUT_FIFO_DEPTH+1);
  localparam int unsigned CRW       = OCW + 1;

  logic [7:0]    mem_even [MEM_DEPTH];
  logic [7:0]    mem_odd  [MEM_DEPTH];
  logic [7:0]    rd_even_q, rd_odd_q;

  logic          take;
  logic          par;
  logic [HW-1:0] h0;
  logic [IW-1:0] base, idx_lo, idx_hi;
  logic          we_even, we_odd;
  logic [7:0]    wd_even, wd_odd;
  logic [IW-1:0] wi_even;

  logic          s1_v_q;
  cmd_t          s1_cmd_q;
  logic          s1_par_q;

  // never start more than the output queue can still hold
  assign take = cmd_valid_i &&
                ((CRW'(out_count_i) + CRW'(s1_v_q)) < CRW'(OUT_FIFO_DEPTH));
  assign cmd_pop_o = take;

  assign par    = addr_i[0];
  assign h0     = addr_i[AW-1:1];
  assign base   = cmd_i.bank ? IW'(HALF) : '0;
  assign idx_lo = base + IW'(h0);
  assign idx_hi = idx_lo + IW'(1);

  // the two bytes of one transfer always land in opposite halves
  always_comb begin
    if (par) begin
      we_even = cmd_i.wr1_en;
      wd_even = cmd_i.wr1_data;
      wi_even = idx_hi;
      we_odd  = cmd_i.wr0_en;
      wd_odd  = cmd_i.wr0_data;
    end else begin
      we_even = cmd_i.wr0_en;
      wd_even = cmd_i.wr0_data;
      wi_even = idx_lo;
      we_odd  = cmd_i.wr1_en;
      wd_odd  = cmd_i.wr1_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && we_even) begin
      mem_even[wi_even] <= wd_even;
    end
    if (take && cmd_i.rd_en) begin
      rd_even_q <= mem_even[idx_lo];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && we_odd) begin
      mem_odd[idx_lo] <= wd_odd;
    end
    if (take && cmd_i.rd_en) begin
      rd_odd_q <= mem_odd[idx_lo];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q <= cmd_i;
      s1_par_q <= par;
    end
  end

  assign out_push_o = s1_v_q;

  always_comb begin
    out_o.event_found     = s1_cmd_q.found;
    out_o.event_length    = s1_cmd_q.length;
    out_o.event_truncated = s1_cmd_q.truncated;
    out_o.read_valid      = s1_cmd_q.rd_en;
    if (s1_cmd_q.rd_en) begin
      out_o.read_byte = s1_par_q ? rd_odd_q : rd_even_q;
    end else begin
      out_o.read_byte = '0;
    end
  end

endmodule

// ===== design/sse_led_checker.sv =====
// port-level checks for the sse last-event data extractor, bound to the top level
`timescale 1ns / 1ps
`include "sse_last_event_data_extractor_defines.svh"
module sse_led_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input sse_led_pkg::out_t out_o
);
  import sse_led_pkg::*;

  localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + OUT_FIFO_DEPTH + 2);

  logic [CNT_W-1:0] outst_q;
  logic             in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // items taken in whose results have not been taken out yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      outst_q <= outst_q + CNT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      outst_q <= outst_q - CNT_W'(1);
    end
  end

  `SSE_LED_ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_o))
  `SSE_LED_ASSERT_IMPL(a_no_phantom_result, clk_i, rst_ni, outst_q == '0, empty)
  `SSE_LED_ASSERT_IMPL(a_no_event_no_length, clk_i, rst_ni, !empty && !out_o.event_found, out_o.event_length == '0 && !out_o.event_truncated)
  `SSE_LED_ASSERT_IMPL(a_read_needs_event, clk_i, rst_ni, !empty && out_o.read_valid, out_o.event_found && out_o.event_length != '0)

endmodule

bind sse_last_event_data_extractor sse_led_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);
